@@ rtl/core/pps_pkg.sv @@
// pure pursuit steering: shared constants, codes and interface types
// used by the controller, datapath and top level; depends on nothing
package pps_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int DSQ_W        = 68;
    localparam int ROOT_W       = DSQ_W / 2;
    localparam int REM_W        = ROOT_W + 3;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int SQ_CNT_W     = $clog2(SQRT_STEPS);
    localparam int ACC_W        = ROOT_W + CNT_W;
    localparam int CORDIC_STEPS = 16;
    localparam int COR_CNT_W    = $clog2(CORDIC_STEPS);
    localparam int CW           = 38;
    localparam int ZW           = 34;
    localparam int ANG_W        = 16;

    localparam logic [31:0] WHEELBASE_RST = 32'd195592;
    localparam logic [31:0] LOOKAHEAD_RST = 32'd655360;
    localparam logic signed [CW-1:0] SIN_GAIN = 38'sd652032874;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    localparam logic [1:0] KIND_PATH = 2'd0;
    localparam logic [1:0] KIND_POSE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_I,
        OP_DIFF_CAR,
        OP_MULX,
        OP_MULY,
        OP_ADDY,
        OP_NR_CMP,
        OP_WK_INIT,
        OP_LDPREV,
        OP_RD_J,
        OP_DIFF_PREV,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_WK_ACC,
        OP_RD_T,
        OP_ATAN_BEAR,
        OP_CORDIC,
        OP_SIN_INIT,
        OP_S15,
        OP_PROD,
        OP_NUM,
        OP_ATAN_STEER,
        OP_OUT,
        OP_OUT_ZERO
    } pps_op_t;

    typedef struct packed {
        pps_op_t op;
    } pps_cmd_t;

    typedef struct packed {
        logic tick_go;
        logic nr_last;
        logic wk_hit;
        logic wk_last;
        logic sq_done;
        logic cor_done;
    } pps_stat_t;

endpackage

@@ rtl/core/pps_ram.sv @@
// generic simple dual-port ram with registered read
// no dependencies
module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/pps_dp.sv @@
// pure pursuit datapath: path memory, pose, squarer, square root, cordic
// depends on pps_pkg and pps_ram
module pps_dp import pps_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pps_cmd_t                 cmd,
    input  logic [1:0]               in_kind,
    input  logic [IDX_W-1:0]         in_index,
    input  logic                     in_last,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [ANG_W-1:0]  in_heading,
    input  logic [31:0]              wheelbase,
    input  logic [31:0]              lookahead,
    output pps_stat_t                stat,
    output logic                     res_ready,
    output logic [IDX_W-1:0]         res_near,
    output logic [IDX_W-1:0]         res_tgt,
    output logic signed [COORD_W-1:0] res_x,
    output logic signed [COORD_W-1:0] res_y,
    output logic signed [ANG_W-1:0]  res_steer
);

    localparam logic signed [ZW-1:0] Z_QTR  = 34'sh040000000;
    localparam logic signed [ZW-1:0] Z_HALF = 34'sh080000000;

    // stored state
    logic signed [COORD_W-1:0] car_x_reg, car_y_reg;
    logic [ANG_W-1:0]          car_hdg_reg;
    logic                      pose_rdy_reg, path_rdy_reg;
    logic [CNT_W-1:0]          count_reg;

    // walk state
    logic [IDX_W-1:0] i_reg, near_reg, tgt_reg;
    logic [CNT_W-1:0] step_reg;
    logic [DSQ_W-1:0] best_reg, dsq_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic [DIFF_W-1:0] mx_reg, my_reg;
    logic [33:0] hh_reg;
    logic [32:0] hl_reg;
    logic [31:0] ll_reg;

    // square root
    logic [DSQ_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg, dist_reg;
    logic [SQ_CNT_W-1:0] sq_cnt_reg;

    // cordic
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [COR_CNT_W-1:0] ccnt_reg;
    logic                 cvec_reg, cspec_reg;
    logic [31:0]          csang_reg;
    logic signed [16:0]   s15_reg;
    logic [47:0]          prod_reg;
    logic signed [CW-1:0] num_reg;

    // memory
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [2*COORD_W-1:0] ram_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y;

    pps_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_index),
        .wdata ({in_x, in_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_we = (cmd.op == OP_ACCEPT) && (in_kind == KIND_PATH);
    assign rd_x   = signed'(ram_rdata[2*COORD_W-1:COORD_W]);
    assign rd_y   = signed'(ram_rdata[COORD_W-1:0]);

    // cyclic successor of i
    logic [CNT_W-1:0] i_inc;
    logic [IDX_W-1:0] j_idx;
    assign i_inc = {1'b0, i_reg} + CNT_W'(1);
    assign j_idx = (i_inc >= count_reg) ? '0 : i_inc[IDX_W-1:0];

    always_comb begin
        unique case (cmd.op)
            OP_WK_INIT: ram_raddr = near_reg;
            OP_RD_J:    ram_raddr = j_idx;
            OP_RD_T:    ram_raddr = tgt_reg;
            default:    ram_raddr = i_reg;
        endcase
    end

    // difference and magnitude
    logic signed [COORD_W-1:0] bx, by;
    logic signed [DIFF_W-1:0]  dx_n, dy_n;
    logic [DIFF_W-1:0]         mx_n, my_n;
    assign bx   = (cmd.op == OP_DIFF_PREV) ? prev_x_reg : car_x_reg;
    assign by   = (cmd.op == OP_DIFF_PREV) ? prev_y_reg : car_y_reg;
    assign dx_n = {rd_x[COORD_W-1], rd_x} - {bx[COORD_W-1], bx};
    assign dy_n = {rd_y[COORD_W-1], rd_y} - {by[COORD_W-1], by};
    assign mx_n = dx_n[DIFF_W-1] ? DIFF_W'(-dx_n) : DIFF_W'(dx_n);
    assign my_n = dy_n[DIFF_W-1] ? DIFF_W'(-dy_n) : DIFF_W'(dy_n);

    // square in three partial products of a 17-bit high and a 16-bit low half, one coordinate a cycle
    logic [DIFF_W-1:0] msrc;
    logic [16:0]       mh;
    logic [15:0]       ml;
    logic [DSQ_W-1:0]  pp_sum;
    assign msrc   = (cmd.op == OP_MULY) ? my_reg : mx_reg;
    assign mh     = msrc[32:16];
    assign ml     = msrc[15:0];
    assign pp_sum = {hh_reg, 32'b0} + DSQ_W'({hl_reg, 17'b0}) + DSQ_W'(ll_reg);

    // square root step
    logic [REM_W-1:0] rem_t, trial;
    assign rem_t = {rem_reg[REM_W-3:0], rad_reg[DSQ_W-1:DSQ_W-2]};
    assign trial = REM_W'({root_reg, 2'b01});

    // walk
    logic [ACC_W-1:0] acc_sum;
    assign acc_sum = acc_reg + ACC_W'(root_reg);

    // cordic angle in 2^32 per turn and its rounding to 16 bits
    logic [31:0]      cor_ang, rnd_ang;
    logic [ANG_W-1:0] rnd16, alpha;
    assign cor_ang = cspec_reg ? csang_reg : cz_reg[31:0];
    assign rnd_ang = cor_ang + 32'h8000;
    assign rnd16   = rnd_ang[31:16];
    assign alpha   = rnd16 - car_hdg_reg;

    // vectoring start with quadrant fix and exact axis cases
    logic signed [CW-1:0] ai_x, ai_y, ini_x, ini_y;
    logic [31:0]          ini_ang;
    logic                 ini_spec;
    always_comb begin
        if (cmd.op == OP_ATAN_STEER) begin
            ai_x = signed'(CW'(dist_reg));
            ai_y = num_reg;
        end else begin
            ai_x = {{(CW-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
            ai_y = {{(CW-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
        end
        ini_x    = ai_x;
        ini_y    = ai_y;
        ini_ang  = '0;
        ini_spec = 1'b0;
        if (ai_x == 0) begin
            ini_spec = 1'b1;
            if (ai_y == 0) begin
                ini_ang = 32'h0;
            end else if (ai_y > 0) begin
                ini_ang = 32'h4000_0000;
            end else begin
                ini_ang = 32'hC000_0000;
            end
        end else if (ai_x < 0) begin
            if (ai_y == 0) begin
                ini_spec = 1'b1;
                ini_ang  = 32'h8000_0000;
            end else if (ai_y > 0) begin
                ini_x   = ai_y;
                ini_y   = -ai_x;
                ini_ang = 32'h4000_0000;
            end else begin
                ini_x   = -ai_y;
                ini_y   = ai_x;
                ini_ang = 32'hC000_0000;
            end
        end
    end

    // rotation start: fold alpha into the right half plane
    logic signed [ZW-1:0] zz, zf;
    assign zz = {{2{alpha[ANG_W-1]}}, alpha, 16'b0};
    always_comb begin
        if (zz > Z_QTR) begin
            zf = Z_HALF - zz;
        end else if (zz < -Z_QTR) begin
            zf = -Z_HALF - zz;
        end else begin
            zf = zz;
        end
    end

    // cordic iteration
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] tz;
    logic                 up;
    assign xs = cx_reg >>> ccnt_reg;
    assign ys = cy_reg >>> ccnt_reg;
    assign tz = signed'(ZW'(ATAN_TAB[5'(ccnt_reg)]));
    assign up = cvec_reg ? (cy_reg > 0) : (cz_reg < 0);

    // sine to q15 with clamp, then numerator rounding
    logic signed [CW-1:0] s_t, s_sh;
    logic signed [16:0]   s15_n, s15_mag;
    logic [49:0]          num_rnd;
    logic [CW-1:0]        num_abs;
    assign s_t  = cy_reg + CW'(16384);
    assign s_sh = s_t >>> 15;
    always_comb begin
        if (s_sh > CW'(32768)) begin
            s15_n = 17'sd32768;
        end else if (s_sh < -CW'(32768)) begin
            s15_n = -17'sd32768;
        end else begin
            s15_n = s_sh[16:0];
        end
    end
    assign s15_mag = s15_reg[16] ? -s15_reg : s15_reg;
    assign num_rnd = {1'b0, prod_reg, 1'b0} + 50'd16384;
    assign num_abs = CW'(num_rnd[49:15]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_x_reg    <= '0;
            car_y_reg    <= '0;
            car_hdg_reg  <= '0;
            pose_rdy_reg <= 1'b0;
            path_rdy_reg <= 1'b0;
            count_reg    <= '0;
        end else if (cmd.op == OP_ACCEPT) begin
            if (in_kind == KIND_PATH) begin
                if (in_last) begin
                    count_reg    <= {1'b0, in_index} + CNT_W'(1);
                    path_rdy_reg <= 1'b1;
                end else if (in_index == '0) begin
                    path_rdy_reg <= 1'b0;
                end
            end else if (in_kind == KIND_POSE) begin
                car_x_reg    <= in_x;
                car_y_reg    <= in_y;
                car_hdg_reg  <= in_heading;
                pose_rdy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ACCEPT: begin
                i_reg <= '0;
            end
            OP_DIFF_CAR, OP_DIFF_PREV: begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
                dx_reg    <= dx_n;
                dy_reg    <= dy_n;
                mx_reg    <= mx_n;
                my_reg    <= my_n;
            end
            OP_MULX: begin
                hh_reg <= mh * mh;
                hl_reg <= mh * ml;
                ll_reg <= ml * ml;
            end
            OP_MULY: begin
                dsq_reg <= pp_sum;
                hh_reg  <= mh * mh;
                hl_reg  <= mh * ml;
                ll_reg  <= ml * ml;
            end
            OP_ADDY: begin
                dsq_reg <= dsq_reg + pp_sum;
            end
            OP_NR_CMP: begin
                if (i_reg == '0 || dsq_reg < best_reg) begin
                    best_reg <= dsq_reg;
                    near_reg <= i_reg;
                end
                i_reg <= i_inc[IDX_W-1:0];
            end
            OP_WK_INIT: begin
                i_reg    <= near_reg;
                tgt_reg  <= near_reg;
                acc_reg  <= '0;
                step_reg <= '0;
            end
            OP_LDPREV: begin
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
            end
            OP_SQ_INIT: begin
                rad_reg    <= dsq_reg;
                rem_reg    <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= '0;
            end
            OP_SQ_STEP: begin
                rad_reg    <= {rad_reg[DSQ_W-3:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg + SQ_CNT_W'(1);
                if (rem_t >= trial) begin
                    rem_reg  <= rem_t - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_t;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            OP_WK_ACC: begin
                acc_reg <= acc_sum;
                if (acc_sum >= ACC_W'(lookahead)) begin
                    tgt_reg <= j_idx;
                end else begin
                    i_reg      <= j_idx;
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                    step_reg   <= step_reg + CNT_W'(1);
                end
            end
            OP_ATAN_BEAR, OP_ATAN_STEER: begin
                if (cmd.op == OP_ATAN_BEAR) begin
                    dist_reg <= root_reg;
                end
                cx_reg    <= ini_x;
                cy_reg    <= ini_y;
                cz_reg    <= signed'({2'b00, ini_ang});
                cspec_reg <= ini_spec;
                csang_reg <= ini_ang;
                cvec_reg  <= 1'b1;
                ccnt_reg  <= '0;
            end
            OP_SIN_INIT: begin
                cx_reg    <= SIN_GAIN;
                cy_reg    <= '0;
                cz_reg    <= zf;
                cspec_reg <= 1'b0;
                cvec_reg  <= 1'b0;
                ccnt_reg  <= '0;
            end
            OP_CORDIC: begin
                ccnt_reg <= ccnt_reg + COR_CNT_W'(1);
                if (up) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + tz;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - tz;
                end
            end
            OP_S15: begin
                s15_reg <= s15_n;
            end
            OP_PROD: begin
                prod_reg <= wheelbase * s15_mag[15:0];
            end
            OP_NUM: begin
                num_reg <= s15_reg[16] ? -signed'(num_abs) : signed'(num_abs);
            end
            OP_OUT: begin
                res_ready <= 1'b1;
                res_near  <= near_reg;
                res_tgt   <= tgt_reg;
                res_x     <= cur_x_reg;
                res_y     <= cur_y_reg;
                res_steer <= rnd16;
            end
            OP_OUT_ZERO: begin
                res_ready <= 1'b0;
                res_near  <= '0;
                res_tgt   <= '0;
                res_x     <= '0;
                res_y     <= '0;
                res_steer <= '0;
            end
            default: begin
            end
        endcase
    end

    assign stat.tick_go  = path_rdy_reg && pose_rdy_reg && (count_reg != '0);
    assign stat.nr_last  = (i_inc == count_reg);
    assign stat.wk_hit   = (acc_sum >= ACC_W'(lookahead));
    assign stat.wk_last  = ((step_reg + CNT_W'(1)) == count_reg);
    assign stat.sq_done  = (sq_cnt_reg == SQ_CNT_W'(SQRT_STEPS - 1));
    assign stat.cor_done = (ccnt_reg == COR_CNT_W'(CORDIC_STEPS - 1));

`ifndef SYNTHESIS
    a_path_count: assert property (@(posedge aclk) disable iff (!aresetn)
        path_rdy_reg |-> count_reg != '0)
        else $error("path marked ready with empty point count");
    a_nr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_NR_CMP |-> {1'b0, i_reg} < count_reg)
        else $error("nearest search beyond point count");
    a_wk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_WK_ACC |-> step_reg < count_reg)
        else $error("walk ran past one full lap");
    a_acc_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_WK_ACC |=> acc_reg >= $past(acc_reg))
        else $error("path length sum decreased");
`endif

endmodule

@@ rtl/core/pps_ctrl.sv @@
// pure pursuit controller: sequences request handling, search, walk and angles
// depends on pps_pkg
module pps_ctrl import pps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_kind,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  pps_stat_t  stat,
    output pps_cmd_t   cmd
);

    localparam logic [5:0] ST_IDLE    = 6'd0;
    localparam logic [5:0] ST_ZERO    = 6'd1;
    localparam logic [5:0] ST_NR_RD   = 6'd2;
    localparam logic [5:0] ST_NR_DIFF = 6'd3;
    localparam logic [5:0] ST_NR_MULX = 6'd4;
    localparam logic [5:0] ST_NR_MULY = 6'd5;
    localparam logic [5:0] ST_NR_ADDY = 6'd6;
    localparam logic [5:0] ST_NR_CMP  = 6'd7;
    localparam logic [5:0] ST_WK_INIT = 6'd8;
    localparam logic [5:0] ST_WK_LDP  = 6'd9;
    localparam logic [5:0] ST_WK_RDJ  = 6'd10;
    localparam logic [5:0] ST_WK_DIFF = 6'd11;
    localparam logic [5:0] ST_WK_MULX = 6'd12;
    localparam logic [5:0] ST_WK_MULY = 6'd13;
    localparam logic [5:0] ST_WK_ADDY = 6'd14;
    localparam logic [5:0] ST_WK_SQI  = 6'd15;
    localparam logic [5:0] ST_WK_SQRT = 6'd16;
    localparam logic [5:0] ST_WK_ACC  = 6'd17;
    localparam logic [5:0] ST_FN_RD   = 6'd18;
    localparam logic [5:0] ST_FN_DIFF = 6'd19;
    localparam logic [5:0] ST_FN_MULX = 6'd20;
    localparam logic [5:0] ST_FN_MULY = 6'd21;
    localparam logic [5:0] ST_FN_ADDY = 6'd22;
    localparam logic [5:0] ST_FN_SQI  = 6'd23;
    localparam logic [5:0] ST_FN_SQRT = 6'd24;
    localparam logic [5:0] ST_FN_ATI  = 6'd25;
    localparam logic [5:0] ST_FN_ATAN = 6'd26;
    localparam logic [5:0] ST_FN_SINI = 6'd27;
    localparam logic [5:0] ST_FN_SIN  = 6'd28;
    localparam logic [5:0] ST_FN_S15  = 6'd29;
    localparam logic [5:0] ST_FN_PROD = 6'd30;
    localparam logic [5:0] ST_FN_NUM  = 6'd31;
    localparam logic [5:0] ST_FN_ATS  = 6'd32;
    localparam logic [5:0] ST_FN_STR  = 6'd33;
    localparam logic [5:0] ST_DONE    = 6'd34;

    logic [5:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free, load;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                    if (s_kind == KIND_TICK) begin
                        state_next = stat.tick_go ? ST_NR_RD : ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    cmd.op     = OP_OUT_ZERO;
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_NR_RD:   begin cmd.op = OP_RD_I;     state_next = ST_NR_DIFF; end
            ST_NR_DIFF: begin cmd.op = OP_DIFF_CAR; state_next = ST_NR_MULX; end
            ST_NR_MULX: begin cmd.op = OP_MULX;     state_next = ST_NR_MULY; end
            ST_NR_MULY: begin cmd.op = OP_MULY;     state_next = ST_NR_ADDY; end
            ST_NR_ADDY: begin cmd.op = OP_ADDY;     state_next = ST_NR_CMP;  end
            ST_NR_CMP: begin
                cmd.op     = OP_NR_CMP;
                state_next = stat.nr_last ? ST_WK_INIT : ST_NR_RD;
            end
            ST_WK_INIT: begin cmd.op = OP_WK_INIT;   state_next = ST_WK_LDP;  end
            ST_WK_LDP:  begin cmd.op = OP_LDPREV;    state_next = ST_WK_RDJ;  end
            ST_WK_RDJ:  begin cmd.op = OP_RD_J;      state_next = ST_WK_DIFF; end
            ST_WK_DIFF: begin cmd.op = OP_DIFF_PREV; state_next = ST_WK_MULX; end
            ST_WK_MULX: begin cmd.op = OP_MULX;      state_next = ST_WK_MULY; end
            ST_WK_MULY: begin cmd.op = OP_MULY;      state_next = ST_WK_ADDY; end
            ST_WK_ADDY: begin cmd.op = OP_ADDY;      state_next = ST_WK_SQI;  end
            ST_WK_SQI:  begin cmd.op = OP_SQ_INIT;   state_next = ST_WK_SQRT; end
            ST_WK_SQRT: begin
                cmd.op = OP_SQ_STEP;
                if (stat.sq_done) begin
                    state_next = ST_WK_ACC;
                end
            end
            ST_WK_ACC: begin
                cmd.op = OP_WK_ACC;
                // a hit or a full lap both end the walk
                if (stat.wk_hit || stat.wk_last) begin
                    state_next = ST_FN_RD;
                end else begin
                    state_next = ST_WK_RDJ;
                end
            end
            ST_FN_RD:   begin cmd.op = OP_RD_T;     state_next = ST_FN_DIFF; end
            ST_FN_DIFF: begin cmd.op = OP_DIFF_CAR; state_next = ST_FN_MULX; end
            ST_FN_MULX: begin cmd.op = OP_MULX;     state_next = ST_FN_MULY; end
            ST_FN_MULY: begin cmd.op = OP_MULY;     state_next = ST_FN_ADDY; end
            ST_FN_ADDY: begin cmd.op = OP_ADDY;     state_next = ST_FN_SQI;  end
            ST_FN_SQI:  begin cmd.op = OP_SQ_INIT;  state_next = ST_FN_SQRT; end
            ST_FN_SQRT: begin
                cmd.op = OP_SQ_STEP;
                if (stat.sq_done) begin
                    state_next = ST_FN_ATI;
                end
            end
            ST_FN_ATI: begin cmd.op = OP_ATAN_BEAR; state_next = ST_FN_ATAN; end
            ST_FN_ATAN: begin
                cmd.op = OP_CORDIC;
                if (stat.cor_done) begin
                    state_next = ST_FN_SINI;
                end
            end
            ST_FN_SINI: begin cmd.op = OP_SIN_INIT; state_next = ST_FN_SIN; end
            ST_FN_SIN: begin
                cmd.op = OP_CORDIC;
                if (stat.cor_done) begin
                    state_next = ST_FN_S15;
                end
            end
            ST_FN_S15:  begin cmd.op = OP_S15;        state_next = ST_FN_PROD; end
            ST_FN_PROD: begin cmd.op = OP_PROD;       state_next = ST_FN_NUM;  end
            ST_FN_NUM:  begin cmd.op = OP_NUM;        state_next = ST_FN_ATS;  end
            ST_FN_ATS:  begin cmd.op = OP_ATAN_STEER; state_next = ST_FN_STR;  end
            ST_FN_STR: begin
                cmd.op = OP_CORDIC;
                if (stat.cor_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.op     = OP_OUT;
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result loaded over an untaken result");
    a_tick_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && s_valid && s_kind == KIND_TICK |=> state_reg != ST_IDLE)
        else $error("tick request did not start work");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("result load did not raise valid");
`endif

endmodule

@@ rtl/core/pure_pursuit_steering.sv @@
// pure pursuit steering top level: apb registers, controller and datapath
// depends on pps_pkg, pps_ctrl, pps_dp (and pps_ram below it)
//
//   channel  direction  handshake               payload
//   s_       in         s_valid / s_ready       kind, point index, last, x, y, heading
//   m_       out        m_valid / m_ready       ready, nearest, target index, x, y, steer
//   apb      in         psel/penable/pwrite     wheelbase at 0x0, lookahead at 0x4
//
// path point and pose requests are stored as they are accepted; a tick with n points
// searches all n points, then walks s segments (s <= n): one memory read and a
// 34-step square root per segment, then three 16-step cordic passes
// reset is synchronous and clears pose, path ready and point count; no memory sweep
// a finished result waits in the output register while the next request is taken
module pure_pursuit_steering import pps_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_kind,
    input  logic [IDX_W-1:0]          s_point_index,
    input  logic                      s_last_point,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    input  logic signed [ANG_W-1:0]   s_heading,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ready_res,
    output logic [IDX_W-1:0]          m_nearest_index,
    output logic [IDX_W-1:0]          m_target_index,
    output logic signed [COORD_W-1:0] m_target_x,
    output logic signed [COORD_W-1:0] m_target_y,
    output logic signed [ANG_W-1:0]   m_steer_angle,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic REG_WHEELBASE = 1'b0;
    localparam logic REG_LOOKAHEAD = 1'b1;

    logic [31:0] wheelbase_reg, lookahead_reg;
    logic        cfg_we;
    pps_cmd_t    cmd;
    pps_stat_t   stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LOOKAHEAD) ? lookahead_reg : wheelbase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg <= WHEELBASE_RST;
            lookahead_reg <= LOOKAHEAD_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_WHEELBASE) begin
                wheelbase_reg <= pwdata;
            end else begin
                lookahead_reg <= pwdata;
            end
        end
    end

    pps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pps_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_kind    (s_kind),
        .in_index   (s_point_index),
        .in_last    (s_last_point),
        .in_x       (s_x_coord),
        .in_y       (s_y_coord),
        .in_heading (s_heading),
        .wheelbase  (wheelbase_reg),
        .lookahead  (lookahead_reg),
        .stat       (stat),
        .res_ready  (m_ready_res),
        .res_near   (m_nearest_index),
        .res_tgt    (m_target_index),
        .res_x      (m_target_x),
        .res_y      (m_target_y),
        .res_steer  (m_steer_angle)
    );

endmodule
